/* sv/isaac_pkg.sv */
// isaac_pkg: sizes, word types, item kinds and control structs of the ISAAC generator.
// Depends on nothing; every other file of the block imports it.
`default_nettype none

package isaac_pkg;

  localparam int LOG2_SIZE    = 8;
  localparam int SIZE         = 1 << LOG2_SIZE;
  localparam int HALF         = SIZE / 2;
  localparam int SEED_INDEX_W = 8;
  localparam int WIDE_W       = (LOG2_SIZE > SEED_INDEX_W) ? LOG2_SIZE : SEED_INDEX_W;

  typedef logic [31:0]             word_t;
  typedef logic [LOG2_SIZE-1:0]    addr_t;
  typedef logic [LOG2_SIZE:0]      count_t;
  typedef logic [2:0]              kind_field_t;
  typedef logic [SEED_INDEX_W-1:0] seed_index_t;

  typedef enum logic [2:0] {
    KIND_SEED  = 3'd0,
    KIND_SET_A = 3'd1,
    KIND_SET_B = 3'd2,
    KIND_SET_C = 3'd3,
    KIND_NEXT  = 3'd4
  } kind_t;

  // Seed write toward the round engine, valid for one cycle.
  typedef struct packed {
    logic  load;
    kind_t kind;
    addr_t addr;
    word_t value;
  } seed_cmd_t;

  // Round start and result buffer read port.
  typedef struct packed {
    logic  start;
    logic  rd_en;
    addr_t rd_addr;
  } rnd_ctrl_t;

  // Fold the 8-bit seed index onto the state memory depth.
  function automatic addr_t seed_addr(seed_index_t idx);
    logic [WIDE_W-1:0] wide;
    wide = WIDE_W'(idx);
    return wide[LOG2_SIZE-1:0];
  endfunction

  // Mixing shift chosen by the low two bits of the step index.
  function automatic word_t mix_word(word_t a, logic [1:0] phase);
    word_t m;
    case (phase)
      2'd0:    m = a << 13;
      2'd1:    m = a >> 6;
      2'd2:    m = a << 2;
      default: m = a >> 16;
    endcase
    return m;
  endfunction

endpackage

`default_nettype wire

/* sv/isaac_req_if.sv */
// isaac_req_if: request channel (seed and next-word items) with valid/ready handshake.
// Depends on isaac_pkg for the field types.
`default_nettype none

interface isaac_req_if;
  import isaac_pkg::*;

  logic        valid;
  logic        ready;
  kind_field_t kind;
  seed_index_t seed_index;
  word_t       seed_value;

  modport source (output valid, output kind, output seed_index, output seed_value,
                  input ready);
  modport sink   (input valid, input kind, input seed_index, input seed_value,
                  output ready);
endinterface

`default_nettype wire

/* sv/isaac_rsp_if.sv */
// isaac_rsp_if: result channel carrying one random word per handshake.
// Depends on isaac_pkg for the word type.
`default_nettype none

interface isaac_rsp_if;
  import isaac_pkg::*;

  logic  valid;
  logic  ready;
  word_t random_word;

  modport source (output valid, output random_word, input ready);
  modport sink   (input valid, input random_word, output ready);
endinterface

`default_nettype wire

/* sv/isaac_random_generator_top.sv */
// isaac_random_generator_top: ISAAC 32-bit generator, handshake control and result output.
// Depends on isaac_pkg, isaac_req_if, isaac_rsp_if and isaac_round.
//
// Usage
//   req carries one item per word: kind 0 writes seed_value into state memory
//   entry seed_index, kinds 1, 2 and 3 load the a, b and c accumulators, kind 4
//   asks for the next random word. Kinds 5 to 7 are dropped. Every seed item
//   marks the result buffer as used up, so the next request starts a new round.
//   rsp returns one random_word for each kind 4 item, in request order.
//
// Sequencing
//   A seed item is taken without leaving idle. A next-word request served from
//   the buffer reads the entry into the buffer read register, then loads it into
//   the output register and shows it on rsp; req is ready again once it is loaded.
//   No new request is taken while a word is fetched or a round runs. A request
//   that finds the buffer empty first runs a round: 256 steps, each through R_H,
//   R_I, R_Y and R_B with four reads through the single state memory read port;
//   the buffer read and the delivery then follow as above.
//
// Reset clears the accumulators, round counter and unread count; both memories
// hold garbage until seeded or filled by a round. When rsp stalls, the word
// holds in the output register and req keeps accepting seed items; a further
// next-word request is taken, but its word waits until the held word is taken.
`default_nettype none

module isaac_random_generator_top (
  input  logic        clk,
  input  logic        rst,
  isaac_req_if.sink   req,
  isaac_rsp_if.source rsp
);
  import isaac_pkg::*;

  typedef enum logic [3:0] {
    T_IDLE    = 4'b0001,
    T_ROUND   = 4'b0010,
    T_READ    = 4'b0100,
    T_DELIVER = 4'b1000
  } tstate_t;

  tstate_t   state;
  count_t    unread;
  count_t    unread_dec;
  seed_cmd_t seed;
  rnd_ctrl_t ctrl;
  logic      core_done;
  word_t     res_rdata;
  logic      req_fire;
  logic      is_seed, is_next;
  logic      out_free;
  kind_t     req_kind;
  word_t     out_word;
  logic      out_valid;

  assign req_kind   = kind_t'(req.kind);
  assign req.ready  = (state == T_IDLE);
  assign req_fire   = req.valid && req.ready;
  assign unread_dec = unread - count_t'(1);
  assign out_free   = !out_valid || rsp.ready;

  always_comb begin
    is_seed = 1'b0;
    is_next = 1'b0;
    case (req_kind)
      KIND_SEED, KIND_SET_A, KIND_SET_B, KIND_SET_C: is_seed = 1'b1;
      KIND_NEXT: is_next = 1'b1;
      default: ;
    endcase
  end

  // Seed writes go straight through to the round engine.
  assign seed.load  = req_fire && is_seed;
  assign seed.kind  = req_kind;
  assign seed.addr  = seed_addr(req.seed_index);
  assign seed.value = req.seed_value;

  // Start a round on an empty buffer; otherwise read the next entry downward.
  assign ctrl.start   = req_fire && is_next && (unread == '0);
  assign ctrl.rd_en   = (req_fire && is_next && (unread != '0)) || (state == T_READ);
  assign ctrl.rd_addr = unread_dec[LOG2_SIZE-1:0];

  isaac_round u_round (
    .clk       (clk),
    .rst       (rst),
    .seed      (seed),
    .ctrl      (ctrl),
    .done      (core_done),
    .res_rdata (res_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= T_IDLE;
      unread    <= '0;
      out_valid <= 1'b0;
    end else begin
      // Load a new word when free; otherwise drop valid once it is taken.
      if (state == T_DELIVER && out_free) begin
        out_valid <= 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        T_IDLE: begin
          if (req_fire && is_seed) begin
            unread <= '0;
          end else if (req_fire && is_next) begin
            if (unread == '0) begin
              state <= T_ROUND;
            end else begin
              unread <= unread_dec;
              state  <= T_DELIVER;
            end
          end
        end
        T_ROUND: begin
          if (core_done) begin
            unread <= count_t'(SIZE);
            state  <= T_READ;
          end
        end
        T_READ: begin
          unread <= unread_dec;
          state  <= T_DELIVER;
        end
        T_DELIVER: begin
          // Hold the fetched word until the output register frees up.
          if (out_free) begin
            state <= T_IDLE;
          end
        end
        default: state <= T_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == T_DELIVER && out_free) begin
      out_word <= res_rdata;
    end
  end

  assign rsp.valid       = out_valid;
  assign rsp.random_word = out_word;

  // A round only starts on an empty buffer.
  a_start_empty: assert property (@(posedge clk) disable iff (rst)
    ctrl.start |-> unread == '0)
    else $error("round started with unread results");

  // Unread count never exceeds the buffer depth.
  a_unread_range: assert property (@(posedge clk) disable iff (rst)
    unread <= count_t'(SIZE))
    else $error("unread count out of range");

  // Round completion is followed by the buffer read.
  a_done_read: assert property (@(posedge clk) disable iff (rst)
    core_done |=> state == T_READ)
    else $error("round done not followed by read");

  // A buffer read is always followed by delivery of that word.
  a_read_deliver: assert property (@(posedge clk) disable iff (rst)
    ctrl.rd_en |=> state == T_DELIVER)
    else $error("buffer read without delivery");

endmodule

`default_nettype wire

/* sv/isaac_round.sv */
// isaac_round: state memory, result buffer, accumulators and the round sequencer.
// Depends on isaac_pkg.
`default_nettype none

module isaac_round (
  input  logic                  clk,
  input  logic                  rst,
  input  isaac_pkg::seed_cmd_t  seed,
  input  isaac_pkg::rnd_ctrl_t  ctrl,
  output logic                  done,
  output isaac_pkg::word_t      res_rdata
);
  import isaac_pkg::*;

  typedef enum logic [4:0] {
    R_IDLE = 5'b00001,
    R_H    = 5'b00010,
    R_I    = 5'b00100,
    R_Y    = 5'b01000,
    R_B    = 5'b10000
  } rstate_t;

  rstate_t state, state_next;

  word_t mem [SIZE];
  word_t res [SIZE];
  word_t mem_rdata;

  word_t accum_a, accum_b, round_count;
  word_t x, y_reg;
  logic  fwd;
  addr_t step;

  logic  mem_re, mem_we;
  addr_t mem_raddr, mem_waddr;
  word_t mem_wdata;
  word_t y_sum, b_src, b_sum;
  addr_t y_addr;
  logic  last_step;

  assign last_step = (step == addr_t'(SIZE - 1));
  assign y_sum     = mem_rdata + accum_a + accum_b;
  assign y_addr    = y_sum[LOG2_SIZE+2 +: LOG2_SIZE];
  // Same-entry read in the write cycle: take the word just written.
  assign b_src     = fwd ? y_reg : mem_rdata;
  assign b_sum     = b_src + x;

  always_comb begin
    state_next = state;
    mem_re     = 1'b0;
    mem_raddr  = step;
    mem_we     = 1'b0;
    mem_waddr  = step;
    mem_wdata  = y_sum;
    case (state)
      R_IDLE: begin
        if (ctrl.start) begin
          mem_re     = 1'b1;
          mem_raddr  = '0;
          state_next = R_H;
        end
      end
      R_H: begin
        mem_re     = 1'b1;
        mem_raddr  = step + addr_t'(HALF);
        state_next = R_I;
      end
      R_I: begin
        mem_re     = 1'b1;
        mem_raddr  = x[2 +: LOG2_SIZE];
        state_next = R_Y;
      end
      R_Y: begin
        mem_we     = 1'b1;
        mem_re     = 1'b1;
        mem_raddr  = y_addr;
        state_next = R_B;
      end
      R_B: begin
        if (last_step) begin
          state_next = R_IDLE;
        end else begin
          mem_re     = 1'b1;
          mem_raddr  = step + addr_t'(1);
          state_next = R_H;
        end
      end
      default: state_next = R_IDLE;
    endcase
    if (seed.load && seed.kind == KIND_SEED) begin
      mem_we    = 1'b1;
      mem_waddr = seed.addr;
      mem_wdata = seed.value;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      mem_rdata <= mem[mem_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (state == R_B) begin
      res[step] <= b_sum;
    end
    if (ctrl.rd_en) begin
      res_rdata <= res[ctrl.rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= R_IDLE;
      done        <= 1'b0;
      accum_a     <= '0;
      accum_b     <= '0;
      round_count <= '0;
    end else begin
      state <= state_next;
      done  <= (state == R_B) && last_step;
      case (state)
        R_IDLE: begin
          if (ctrl.start) begin
            step        <= '0;
            round_count <= round_count + 32'd1;
            accum_b     <= accum_b + round_count + 32'd1;
          end
        end
        R_H: x <= mem_rdata;
        R_I: accum_a <= (accum_a ^ mix_word(accum_a, step[1:0])) + mem_rdata;
        R_Y: begin
          y_reg <= y_sum;
          fwd   <= (y_addr == step);
        end
        R_B: begin
          accum_b <= b_sum;
          step    <= step + addr_t'(1);
        end
        default: ;
      endcase
      if (seed.load) begin
        case (seed.kind)
          KIND_SET_A: accum_a     <= seed.value;
          KIND_SET_B: accum_b     <= seed.value;
          KIND_SET_C: round_count <= seed.value;
          default:    ;
        endcase
      end
    end
  end

endmodule

`default_nettype wire
